/* hdl/tpc_pkg.sv */
// Shared types and constants for the trie prefix counter.
package tpc_pkg;

	localparam int DEF_NODE_COUNT = 256;
	localparam int DEF_COUNT_BITS = 16;
	localparam int CH_W = 8;
	localparam int PREFIX_W = 16;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL,
		ST_CNT_WR,
		ST_DONE
	} tpc_state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic eval;
		logic cnt_wr;
		logic finish;
	} tpc_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic need_cnt_wr;
	} tpc_sts_t;

endpackage

/* hdl/tpc_ctrl.sv */
// Controller state machine that sequences the clearing pass and each item.
module tpc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tpc_pkg::tpc_sts_t sts,
	output tpc_pkg::tpc_cmd_t cmd,
	output logic              busy
);
	import tpc_pkg::*;

	tpc_state_t state_q;
	tpc_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d = sts.need_cnt_wr ? ST_CNT_WR : ST_DONE;
			end
			ST_CNT_WR: begin
				cmd.cnt_wr = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

/* hdl/tpc_datapath.sv */
// Datapath with the child map, the count memory, the walk registers and the result registers.
module tpc_datapath #(
	parameter int NODE_COUNT = tpc_pkg::DEF_NODE_COUNT,
	parameter int COUNT_BITS = tpc_pkg::DEF_COUNT_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tpc_pkg::tpc_cmd_t           cmd,
	output tpc_pkg::tpc_sts_t           sts,
	input  logic                        command,
	input  logic [tpc_pkg::CH_W-1:0]    ch,
	input  logic                        last,
	output logic [tpc_pkg::PREFIX_W-1:0] prefix_count,
	output logic                        status,
	output logic                        done
);
	import tpc_pkg::*;

	localparam int NODE_W = $clog2(NODE_COUNT);
	localparam int ADDR_W = NODE_W + CH_W;
	localparam int MAP_DEPTH = NODE_COUNT * (2 ** CH_W);
	localparam int FREE_W = NODE_W + 1;

	logic [NODE_W-1:0]     map_mem [MAP_DEPTH];
	logic [COUNT_BITS-1:0] cnt_mem [NODE_COUNT];

	logic [ADDR_W-1:0]     clr_q;
	logic                  command_q;
	logic [CH_W-1:0]       ch_q;
	logic                  last_q;
	logic [NODE_W-1:0]     cursor_q;
	logic                  walk_missed_q;
	logic                  overflowed_q;
	logic [FREE_W-1:0]     next_free_q;
	logic [NODE_W-1:0]     map_rd_q;
	logic [COUNT_BITS-1:0] cnt_rd_q;
	logic [PREFIX_W-1:0]   prefix_count_q;
	logic                  status_q;
	logic                  done_q;

	logic                  is_ins;
	logic                  child_zero;
	logic                  table_full;
	logic                  ins_full;
	logic                  ins_alloc;
	logic                  ins_hit;
	logic                  q_miss;
	logic                  q_hit;
	logic                  map_we;
	logic [ADDR_W-1:0]     map_waddr;
	logic [NODE_W-1:0]     map_wdata;
	logic                  cnt_we;
	logic [NODE_W-1:0]     cnt_waddr;
	logic [COUNT_BITS-1:0] cnt_wdata;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [PREFIX_W-1:0]   cnt_out;

	assign is_ins = (command_q == CMD_INSERT);
	assign child_zero = (map_rd_q == '0);
	assign table_full = (next_free_q == FREE_W'(NODE_COUNT));
	assign ins_full = !overflowed_q && child_zero && table_full;
	assign ins_alloc = !overflowed_q && child_zero && !table_full;
	assign ins_hit = !overflowed_q && !child_zero;
	assign q_miss = !walk_missed_q && child_zero;
	assign q_hit = !walk_missed_q && !child_zero;

	assign sts.clear_done = (clr_q == ADDR_W'(MAP_DEPTH - 1));
	assign sts.need_cnt_wr = is_ins && ins_hit;

	assign cnt_inc = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + COUNT_BITS'(1);

	generate
		if (COUNT_BITS > PREFIX_W) begin : g_clip
			assign cnt_out = ((cnt_rd_q >> PREFIX_W) != '0) ? '1 : cnt_rd_q[PREFIX_W-1:0];
		end else begin : g_ext
			assign cnt_out = PREFIX_W'(cnt_rd_q);
		end
	endgenerate

	always_comb begin
		map_we = 1'b0;
		map_waddr = clr_q;
		map_wdata = '0;
		cnt_we = 1'b0;
		cnt_waddr = cursor_q;
		cnt_wdata = cnt_inc;
		if (cmd.clear) begin
			map_we = 1'b1;
		end else if (cmd.eval && is_ins && ins_alloc) begin
			map_we = 1'b1;
			map_waddr = {cursor_q, ch_q};
			map_wdata = next_free_q[NODE_W-1:0];
			cnt_we = 1'b1;
			cnt_waddr = next_free_q[NODE_W-1:0];
			cnt_wdata = COUNT_BITS'(1);
		end else if (cmd.cnt_wr) begin
			cnt_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
		if (cmd.accept) begin
			map_rd_q <= map_mem[{cursor_q, ch}];
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (cmd.eval) begin
			cnt_rd_q <= cnt_mem[map_rd_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			command_q <= command;
			ch_q <= ch;
			last_q <= last;
		end
		if (cmd.finish && last_q) begin
			prefix_count_q <= (is_ins || walk_missed_q) ? '0 : cnt_out;
			status_q <= is_ins ? overflowed_q : STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			cursor_q <= '0;
			walk_missed_q <= 1'b0;
			overflowed_q <= 1'b0;
			next_free_q <= FREE_W'(1);
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish && last_q;
			if (cmd.clear) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (cmd.eval) begin
				if (is_ins) begin
					if (ins_full) begin
						overflowed_q <= 1'b1;
					end else if (ins_alloc) begin
						cursor_q <= next_free_q[NODE_W-1:0];
						next_free_q <= next_free_q + FREE_W'(1);
					end else if (ins_hit) begin
						cursor_q <= map_rd_q;
					end
				end else begin
					if (q_miss) begin
						walk_missed_q <= 1'b1;
					end else if (q_hit) begin
						cursor_q <= map_rd_q;
					end
				end
			end
			if (cmd.finish && last_q) begin
				cursor_q <= '0;
				walk_missed_q <= 1'b0;
				overflowed_q <= 1'b0;
			end
		end
	end

	assign prefix_count = prefix_count_q;
	assign status = status_q;
	assign done = done_q;

endmodule

/* hdl/trie_prefix_counter.sv */
// Top level of the trie prefix counter: controller, datapath and assertions.
// An item is one byte of a word (ch), a command (insert or prefix query) and a
// last flag. It is accepted at a rising edge where start is high and busy is low.
// Only an item with last set gives a result: prefix_count and status are valid
// for the single cycle in which done is high, and the receiver cannot stall.
// For a query the result is the number of inserted words with that prefix, or 0
// on a miss; for an insert it is 0 with status set if the node table filled.
// Each item reads the child map, then reads or writes the count memory, and an
// insert that passes an existing node does a read-modify-write of its count.
// After acceptance an item passes through EVAL, then CNT_WR for an insert byte
// that reaches an existing node, then DONE, with busy high in those states. done
// rises in the cycle after the last busy cycle of an item with last set.
// After reset the child map is cleared one entry per cycle with busy high;
// node counts need no clearing since each node's count is written when the
// node is allocated.
module trie_prefix_counter #(
	parameter int NODE_COUNT = tpc_pkg::DEF_NODE_COUNT,
	parameter int COUNT_BITS = tpc_pkg::DEF_COUNT_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         command,
	input  logic [tpc_pkg::CH_W-1:0]     ch,
	input  logic                         last,
	output logic                         done,
	output logic [tpc_pkg::PREFIX_W-1:0] prefix_count,
	output logic                         status
);
	import tpc_pkg::*;

	tpc_cmd_t cmd;
	tpc_sts_t sts;

	tpc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	tpc_datapath #(
		.NODE_COUNT (NODE_COUNT),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.command      (command),
		.ch           (ch),
		.last         (last),
		.prefix_count (prefix_count),
		.status       (status),
		.done         (done)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result delivered while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a preceding busy cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STATUS_FULL) |-> (prefix_count == '0))
		else $error("table full result carries a nonzero count");

endmodule

/* bench/trie_prefix_counter_checker.sv */
// Checker for the trie prefix counter: predicts each result and compares it with the block.
module trie_prefix_counter_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic                         command,
	input  logic [tpc_pkg::CH_W-1:0]     ch,
	input  logic                         last,
	input  logic                         done,
	input  logic [tpc_pkg::PREFIX_W-1:0] prefix_count,
	input  logic                         status,
	output int                           fail_count,
	output int                           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import tpc_pkg::*;

	localparam int NODES = DEF_NODE_COUNT;
	localparam int NODE_W = $clog2(NODES);
	localparam int CNT_W = DEF_COUNT_BITS;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef struct packed {
		logic [PREFIX_W-1:0] prefix_count;
		logic                status;
	} word_result_t;

	logic [NODE_W-1:0] child_of [0:NODES*256-1];
	logic [CNT_W-1:0]  word_count [0:NODES-1];
	logic [NODE_W-1:0] cursor;
	logic [NODE_W:0]   free_node;
	logic              query_lost;
	logic              table_full;
	word_result_t      expected_results [$];

	initial begin
		for (int i = 0; i < NODES * 256; i++)
			child_of[i] = '0;
		for (int i = 0; i < NODES; i++)
			word_count[i] = '0;
		cursor = '0;
		free_node = (NODE_W + 1)'(1);
		query_lost = 1'b0;
		table_full = 1'b0;
		fail_count = 0;
		pending = 0;
	end

	task automatic walk_trie(input logic cmd, input logic [CH_W-1:0] c, input logic fin);
		logic [NODE_W-1:0] nxt;
		word_result_t      res;
		if (cmd == CMD_INSERT) begin
			if (!table_full) begin
				nxt = child_of[{cursor, c}];
				if (nxt == '0) begin
					if (free_node >= NODES) begin
						table_full = 1'b1;
					end else begin
						nxt = free_node[NODE_W-1:0];
						free_node++;
						child_of[{cursor, c}] = nxt;
					end
				end
				if (!table_full) begin
					if (word_count[nxt] != CNT_MAX)
						word_count[nxt]++;
					cursor = nxt;
				end
			end
		end else if (!query_lost) begin
			nxt = child_of[{cursor, c}];
			if (nxt == '0)
				query_lost = 1'b1;
			else
				cursor = nxt;
		end
		if (fin) begin
			res.prefix_count = '0;
			res.status = STATUS_OK;
			if (cmd == CMD_INSERT)
				res.status = table_full ? STATUS_FULL : STATUS_OK;
			else if (!query_lost)
				res.prefix_count = PREFIX_W'(word_count[cursor]);
			expected_results.push_back(res);
			cursor = '0;
			query_lost = 1'b0;
			table_full = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		word_result_t want;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: prefix_count %0d status %0d", prefix_count, status);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (prefix_count !== want.prefix_count) begin
						$error("prefix_count: expected %0d, actual %0d",
							want.prefix_count, prefix_count);
						fail_count++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						fail_count++;
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				walk_trie(command, ch, last);
			pending = expected_results.size();
		end
	end

endmodule

/* bench/tb_trie_prefix_counter.sv */
// Testbench top for the trie prefix counter: clock, reset, word stimulus and verdict.
module tb_trie_prefix_counter;
	timeunit 1ns;
	timeprecision 1ps;

	import tpc_pkg::*;

	localparam int RANDOM_ITEMS = 1930;
	localparam int QUIET_TAIL = 150;
	localparam int HOT_REPEATS = 16;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int MAX_LEN = 12;
	localparam logic [CH_W-1:0] HOT_CH = 8'hA5;

	typedef struct packed {
		logic [3:0]                    len;
		logic [MAX_LEN-1:0][CH_W-1:0] text;
	} word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              command = CMD_INSERT;
	logic [CH_W-1:0]   ch = '0;
	logic              last = 1'b0;
	logic              busy;
	logic              done;
	logic [PREFIX_W-1:0] prefix_count;
	logic              status;
	int                fail_count;
	int                pending;
	int                items_sent = 0;
	int                cycle_count = 0;
	bit                idle_on = 1'b1;
	bit                quiet_tail = 1'b0;
	word_t             word_pool [$];

	trie_prefix_counter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.ch           (ch),
		.last         (last),
		.done         (done),
		.prefix_count (prefix_count),
		.status       (status)
	);

	trie_prefix_counter_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.ch           (ch),
		.last         (last),
		.done         (done),
		.prefix_count (prefix_count),
		.status       (status),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always #6 clk = ~clk;

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic [CH_W-1:0] pick_char();
		if ($urandom_range(0, 7) == 0)
			return CH_W'($urandom_range(0, 255));
		return CH_W'(8'h61 + $urandom_range(0, 3));
	endfunction

	task automatic send_byte(input logic cmd, input logic [CH_W-1:0] c, input logic fin);
		if (items_sent % 64 == 0)
			idle_on = ($urandom_range(0, 3) != 0) && !quiet_tail;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		ch <= c;
		last <= fin;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_word(input logic cmd, input word_t w, input int len);
		for (int i = 0; i < len; i++)
			send_byte(cmd, w.text[i], i == len - 1);
	endtask

	task automatic send_mixed(input word_t w);
		for (int i = 0; i < w.len; i++)
			send_byte(logic'($urandom_range(0, 1)), w.text[i], i == w.len - 1);
	endtask

	function automatic word_t random_word();
		word_t w;
		w.text = '0;
		w.len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(7, MAX_LEN))
			: 4'($urandom_range(1, 6));
		for (int i = 0; i < MAX_LEN; i++)
			w.text[i] = pick_char();
		return w;
	endfunction

	initial begin
		word_t w;
		int    pick;
		int    sel;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_byte(CMD_INSERT, HOT_CH, 1'b1);
		send_byte(CMD_QUERY, HOT_CH, 1'b1);
		send_byte(CMD_INSERT, 8'h00, 1'b0);
		send_byte(CMD_INSERT, 8'hFF, 1'b1);
		send_byte(CMD_QUERY, 8'h00, 1'b1);
		send_byte(CMD_QUERY, 8'h00, 1'b0);
		send_byte(CMD_QUERY, 8'hFF, 1'b1);
		send_byte(CMD_QUERY, 8'hFF, 1'b1);
		send_byte(CMD_QUERY, 8'hFF, 1'b0);
		send_byte(CMD_QUERY, 8'h00, 1'b1);
		send_byte(CMD_INSERT, HOT_CH, 1'b0);
		send_byte(CMD_INSERT, 8'h00, 1'b1);
		send_byte(CMD_QUERY, HOT_CH, 1'b1);
		send_byte(CMD_INSERT, 8'h00, 1'b0);
		send_byte(CMD_QUERY, 8'hFF, 1'b1);
		send_byte(CMD_QUERY, 8'h5A, 1'b0);
		send_byte(CMD_INSERT, 8'h5A, 1'b1);
		send_byte(CMD_INSERT, 8'h00, 1'b0);
		send_byte(CMD_QUERY, 8'h00, 1'b1);

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent >= RANDOM_ITEMS - QUIET_TAIL)
				quiet_tail = 1'b1;
			sel = $urandom_range(0, 99);
			if (sel < 35 || word_pool.size() == 0) begin
				w = random_word();
				word_pool.push_back(w);
				send_word(CMD_INSERT, w, w.len);
			end else if (sel < 50) begin
				w = word_pool[$urandom_range(0, word_pool.size() - 1)];
				send_word(CMD_INSERT, w, w.len);
			end else if (sel < 75) begin
				w = word_pool[$urandom_range(0, word_pool.size() - 1)];
				pick = $urandom_range(1, w.len);
				send_word(CMD_QUERY, w, pick);
			end else if (sel < 88) begin
				w = random_word();
				send_word(CMD_QUERY, w, w.len);
			end else begin
				w = random_word();
				send_mixed(w);
			end
		end

		quiet_tail = 1'b1;
		idle_on = 1'b0;
		repeat (HOT_REPEATS)
			send_byte(CMD_INSERT, HOT_CH, 1'b1);
		send_byte(CMD_QUERY, HOT_CH, 1'b1);
		send_byte(CMD_INSERT, HOT_CH, 1'b0);
		send_byte(CMD_INSERT, 8'h3C, 1'b1);
		send_byte(CMD_QUERY, HOT_CH, 1'b1);
		start <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
